### rtl/mll_pkg.sv
// ----------------------------------------------------------------------------
// mll_pkg: shared types, constants and helpers of the mini language lexer
// Character classes, token codes, lexer modes and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package mll_pkg;

  // Widths of the position and length counters
  localparam int unsigned POS_W = 16;
  localparam int unsigned LEN_W = 8;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Only the first five identifier bytes are kept for the keyword check
  localparam int unsigned KW_BYTES = 5;
  localparam int unsigned KW_W     = 8 * KW_BYTES;
  localparam int unsigned KW_NUM   = 8;

  // Token queue sizing: one item can push two tokens
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Token kinds
  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_KEYWORD = 3'd1;
  localparam logic [2:0] KIND_NUMBER  = 3'd2;
  localparam logic [2:0] KIND_OPER    = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // Lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_RELOP   = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_CSTAR   = 3'd6;

  // Characters with a role of their own
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Keywords packed first byte lowest: if else for while do int read write
  localparam logic [KW_W-1:0] KW_TEXT [KW_NUM] = '{
    40'h0000006669, 40'h0065736c65, 40'h0000726f66, 40'h656c696877,
    40'h0000006f64, 40'h0000746e69, 40'h0064616572, 40'h6574697277
  };
  localparam logic [LEN_W-1:0] KW_LEN [KW_NUM] = '{
    8'd2, 8'd4, 8'd3, 8'd5, 8'd2, 8'd3, 8'd4, 8'd5
  };

  typedef struct packed {
    logic [2:0]       kind;
    logic [2:0]       kw_idx;
    logic [7:0]       op_first;
    logic [7:0]       op_second;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
    logic             err;
  } token_t;

  // Tokens produced by one request: a is the flushed one, b the new one
  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } tok_pair_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } kw_res_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // + - * ( ) { } ; , :
  function automatic logic is_single_op(input logic [7:0] c);
    return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h28 || c == 8'h29 ||
           c == 8'h7B || c == 8'h7D || c == 8'h3B || c == 8'h2C || c == 8'h3A;
  endfunction

  // > < = !
  function automatic logic is_rel_op(input logic [7:0] c);
    return c == 8'h3E || c == 8'h3C || c == 8'h3D || c == 8'h21;
  endfunction

  // Parallel compare against all keywords, lowest index wins
  function automatic kw_res_t kw_lookup(input logic [KW_W-1:0] chars,
                                        input logic [LEN_W-1:0] len);
    kw_res_t res;
    res = '0;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (len == KW_LEN[k] && chars == KW_TEXT[k]) begin
        res.hit = 1'b1;
        res.idx = 3'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/mll_core.sv
// ----------------------------------------------------------------------------
// mll_core: lexer state and single-pass token logic
// Consumes one character per step and produces up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module mll_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        char_i,
  input  wire logic              eoi_i,
  output mll_pkg::tok_pair_t     toks_o
);
  import mll_pkg::*;

  logic [2:0]       mode_q, mode_d;
  logic [KW_W-1:0]  kw_q, kw_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       relop_q, relop_d;
  logic             err_q, err_d;

  kw_res_t   kw_res;
  token_t    pend_tok;
  logic      pend_valid;
  tok_pair_t toks;
  logic      classify;

  assign kw_res = kw_lookup(kw_q, len_q);

  // Token left pending by a multi-byte mode
  always_comb begin
    pend_tok       = '0;
    pend_tok.start = start_q;
    pend_tok.err   = err_q;
    pend_valid     = 1'b0;
    unique case (mode_q)
      MODE_IDENT: begin
        pend_valid      = 1'b1;
        pend_tok.kind   = kw_res.hit ? KIND_KEYWORD : KIND_IDENT;
        pend_tok.kw_idx = kw_res.idx;
        pend_tok.len    = len_q;
      end
      MODE_NUMBER: begin
        pend_valid    = 1'b1;
        pend_tok.kind = KIND_NUMBER;
        pend_tok.len  = len_q;
      end
      MODE_RELOP: begin
        pend_valid        = 1'b1;
        pend_tok.kind     = KIND_OPER;
        pend_tok.op_first = relop_q;
        pend_tok.len      = LEN_W'(1);
      end
      MODE_SLASH: begin
        pend_valid        = 1'b1;
        pend_tok.kind     = KIND_OPER;
        pend_tok.op_first = CH_SLASH;
        pend_tok.len      = LEN_W'(1);
      end
      default: ;
    endcase
  end

  // Next state and produced tokens
  always_comb begin
    mode_d   = mode_q;
    kw_d     = kw_q;
    len_d    = len_q;
    start_d  = start_q;
    pos_d    = pos_q;
    relop_d  = relop_q;
    err_d    = err_q;
    toks     = '0;
    toks.a   = pend_tok;
    classify = 1'b0;

    if (eoi_i) begin
      // flush, then back to reset values
      toks.a_valid = pend_valid;
      toks.a.last  = 1'b1;
      mode_d  = MODE_IDLE;
      kw_d    = '0;
      len_d   = '0;
      start_d = '0;
      pos_d   = '0;
      relop_d = '0;
      err_d   = 1'b0;
    end else begin
      pos_d = pos_q + POS_W'(1);
      unique case (mode_q)
        MODE_IDENT: begin
          if (is_letter(char_i) || is_digit(char_i)) begin
            if (len_q < LEN_W'(KW_BYTES)) begin
              kw_d = kw_q | (KW_W'(char_i) << {len_q[2:0], 3'b000});
            end
            if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
          end else begin
            toks.a_valid = 1'b1;
            classify     = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(char_i)) begin
            if (len_q != LEN_MAX) len_d = len_q + LEN_W'(1);
          end else begin
            toks.a_valid = 1'b1;
            classify     = 1'b1;
          end
        end
        MODE_RELOP: begin
          if (char_i == CH_EQ) begin
            toks.b_valid     = 1'b1;
            toks.b.kind      = KIND_OPER;
            toks.b.op_first  = relop_q;
            toks.b.op_second = CH_EQ;
            toks.b.start     = start_q;
            toks.b.len       = LEN_W'(2);
            toks.b.err       = err_q;
            mode_d           = MODE_IDLE;
          end else begin
            toks.a_valid = 1'b1;
            classify     = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (char_i == CH_STAR) begin
            mode_d = MODE_COMMENT;
          end else begin
            toks.a_valid = 1'b1;
            classify     = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (char_i == CH_STAR) mode_d = MODE_CSTAR;
        end
        MODE_CSTAR: begin
          if (char_i == CH_SLASH) mode_d = MODE_IDLE;
          else if (char_i != CH_STAR) mode_d = MODE_COMMENT;
        end
        default: classify = 1'b1;
      endcase

      // Fresh character after idle or after a flushed token
      if (classify) begin
        mode_d = MODE_IDLE;
        if (char_i == CH_SPACE || char_i == CH_TAB || char_i == CH_LF) begin
          // whitespace: nothing
        end else if (is_letter(char_i)) begin
          mode_d  = MODE_IDENT;
          start_d = pos_q;
          len_d   = LEN_W'(1);
          kw_d    = KW_W'(char_i);
        end else if (is_digit(char_i)) begin
          mode_d  = MODE_NUMBER;
          start_d = pos_q;
          len_d   = LEN_W'(1);
        end else if (is_single_op(char_i)) begin
          toks.b_valid    = 1'b1;
          toks.b.kind     = KIND_OPER;
          toks.b.op_first = char_i;
          toks.b.start    = pos_q;
          toks.b.len      = LEN_W'(1);
          toks.b.err      = err_q;
        end else if (is_rel_op(char_i)) begin
          mode_d  = MODE_RELOP;
          relop_d = char_i;
          start_d = pos_q;
        end else if (char_i == CH_SLASH) begin
          mode_d  = MODE_SLASH;
          start_d = pos_q;
        end else begin
          err_d           = 1'b1;
          toks.b_valid    = 1'b1;
          toks.b.kind     = KIND_ERROR;
          toks.b.op_first = char_i;
          toks.b.start    = pos_q;
          toks.b.len      = LEN_W'(1);
          toks.b.err      = 1'b1;
        end
      end
      // last marks the final token of this request
      toks.a.last = !toks.b_valid;
      toks.b.last = 1'b1;
    end
  end

  assign toks_o = toks;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= '0;
      len_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      relop_q <= '0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      len_q   <= len_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      relop_q <= relop_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

### rtl/mll_fifo.sv
// ----------------------------------------------------------------------------
// mll_fifo: small token queue with two-token push and single pop
// Decouples bursts of two tokens from a one-per-cycle output channel that the receiver may stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mll_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire mll_pkg::tok_pair_t toks_i,
  output logic                    room_o,
  output logic                    valid_o,
  input  wire logic               pop_ready_i,
  output mll_pkg::token_t         head_o
);
  import mll_pkg::*;

  token_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cnt_after_pop;
  logic             pop;
  logic [1:0]       push_n;
  token_t           first_tok;

  assign valid_o = cnt_q != '0;
  assign pop     = valid_o && pop_ready_i;
  assign head_o  = mem_q[rptr_q];

  // Room for two tokens once this cycle's pop is counted
  assign cnt_after_pop = cnt_q - CNT_W'(pop);
  assign room_o        = cnt_after_pop <= CNT_W'(FIFO_DEPTH - 2);

  assign push_n    = push_i ? (2'(toks_i.a_valid) + 2'(toks_i.b_valid)) : 2'd0;
  assign first_tok = toks_i.a_valid ? toks_i.a : toks_i.b;

  // Pointer and count update
  always_comb begin
    wptr_d = wptr_q + PTR_W'(push_n);
    rptr_d = rptr_q + PTR_W'(pop);
    cnt_d  = cnt_q + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Token storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wptr_q] <= first_tok;
    end
    if (push_n == 2'd2) begin
      mem_q[wptr_q + PTR_W'(1)] <= toks_i.b;
    end
  end

endmodule

`default_nettype wire

### rtl/mini_language_lexer.sv
// ----------------------------------------------------------------------------
// mini_language_lexer: streaming tokenizer for a small language
// Turns a byte stream into identifier, keyword, number, operator and error
// tokens, one source byte per cycle while the token queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one source byte, or an
//   end-of-input mark that flushes the pending token and restarts offsets.
//   Output channel (out_valid_o / out_ready_i) carries one token per request.
//   A byte is taken into an input register, processed by the lexer logic once
//   the queue has room for two tokens, and then written into a four-entry
//   token queue, whose head entry drives the output.
//   Throughput is one byte per cycle. A byte that both ends a token and forms
//   one pushes two tokens; the queue absorbs these while the output drains one
//   token per cycle, and the byte stage waits only when the queue lacks room
//   for two tokens.
//   When the receiver stalls, the head token holds and the queue fills, then
//   in_ready_o drops. Reset empties the queue and clears lexer state, offsets
//   and the sticky error flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mini_language_lexer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        end_of_input_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       token_kind_o,
  output logic [2:0]       keyword_index_o,
  output logic [7:0]       op_first_o,
  output logic [7:0]       op_second_o,
  output logic [15:0]      start_offset_o,
  output logic [7:0]       token_length_o,
  output logic             last_of_run_o,
  output logic             error_seen_o
);
  import mll_pkg::*;

  logic       in_v_q;
  logic [7:0] char_q;
  logic       eoi_q;
  logic       room;
  logic       step;
  tok_pair_t  toks;
  token_t     head;

  assign step       = in_v_q && room;
  assign in_ready_o = !in_v_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_in_i;
      eoi_q  <= end_of_input_i;
    end
  end

  mll_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (char_q),
    .eoi_i  (eoi_q),
    .toks_o (toks)
  );

  mll_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .toks_i      (toks),
    .room_o      (room),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .head_o      (head)
  );

  // Token fields to ports
  assign token_kind_o    = head.kind;
  assign keyword_index_o = head.kw_idx;
  assign op_first_o      = head.op_first;
  assign op_second_o     = head.op_second;
  assign start_offset_o  = head.start;
  assign token_length_o  = head.len;
  assign last_of_run_o   = head.last;
  assign error_seen_o    = head.err;

endmodule

`default_nettype wire

### rtl/mll_checker.sv
// ----------------------------------------------------------------------------
// mll_checker: port-level checks of the lexer
// Watches the output channel for token consistency and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module mll_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  token_kind_o,
  input wire logic [7:0]  op_first_o,
  input wire logic [7:0]  op_second_o,
  input wire logic [7:0]  token_length_o,
  input wire logic        error_seen_o
);
  import mll_pkg::*;

  // A stalled token holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o) &&
    $stable(op_first_o) && $stable(token_length_o))
    else $error("token changed while stalled");

  // An error token always carries the sticky flag
  a_err_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_ERROR |-> error_seen_o)
    else $error("error token without error flag");

  // Keywords are two to five characters long
  a_kw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_KEYWORD |->
    token_length_o >= 8'd2 && token_length_o <= 8'd5 && op_first_o == 8'd0)
    else $error("bad keyword token");

  // Operators are one or two characters, the second only '='
  a_op_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_OPER |->
    (token_length_o == 8'd1 && op_second_o == 8'd0) ||
    (token_length_o == 8'd2 && op_second_o == CH_EQ))
    else $error("bad operator token");

endmodule

bind mini_language_lexer mll_checker u_mll_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .token_kind_o   (token_kind_o),
  .op_first_o     (op_first_o),
  .op_second_o    (op_second_o),
  .token_length_o (token_length_o),
  .error_seen_o   (error_seen_o)
);

`default_nettype wire
